>>> sv/lsfe_pkg.sv
// Shared types and constants for the LSB stego frame extractor.
`default_nettype none
package lsfe_pkg;

   localparam int unsigned VALUE_W   = 32;
   localparam int unsigned SECTION_W = 3;
   localparam int unsigned HDR_LEN_W = 16;
   localparam int unsigned MAGIC_W   = 8;
   localparam int unsigned BITCNT_W  = 5;
   localparam int unsigned CSR_IDX_W = 1;
   localparam int unsigned CSR_DAT_W = 16;

   localparam logic [HDR_LEN_W-1:0] HEADER_LENGTH_RESET = 16'd54;
   localparam logic [MAGIC_W-1:0]   MAGIC_LENGTH_RESET  = 8'd2;

   // Register indexes of the configuration port.
   localparam logic [CSR_IDX_W-1:0] CSR_HEADER_LENGTH = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_MAGIC_LENGTH  = 1'b1;

   // Section codes carried with each result.
   localparam logic [SECTION_W-1:0] SEC_MAGIC    = 3'd0;
   localparam logic [SECTION_W-1:0] SEC_EXT_LEN  = 3'd1;
   localparam logic [SECTION_W-1:0] SEC_EXT_BYTE = 3'd2;
   localparam logic [SECTION_W-1:0] SEC_PAY_LEN  = 3'd3;
   localparam logic [SECTION_W-1:0] SEC_PAY_BYTE = 3'd4;

   localparam logic [BITCNT_W-1:0] BYTE_LAST_BIT = 5'd7;
   localparam logic [BITCNT_W-1:0] WORD_LAST_BIT = 5'd31;

   typedef enum logic [2:0] {
      PH_HEADER   = 3'd0,
      PH_MAGIC    = 3'd1,
      PH_EXTLEN   = 3'd2,
      PH_EXTBYTES = 3'd3,
      PH_PAYLEN   = 3'd4,
      PH_PAYBYTES = 3'd5,
      PH_DONE     = 3'd6
   } phase_type;

   typedef struct packed {
      logic [VALUE_W-1:0]   out_value;
      logic [SECTION_W-1:0] section;
      logic                 last_in_section;
   } result_type;

   typedef struct packed {
      phase_type            phase;
      logic [BITCNT_W-1:0]  bit_count;
      logic [VALUE_W-1:0]   shift_word;
      logic [VALUE_W-1:0]   items_left;
      logic [HDR_LEN_W-1:0] header_left;
   } parse_state_type;

endpackage
`default_nettype wire

>>> sv/lsfe_parse.sv
// Parse state and decode of the hidden bit stream into bytes and length words.
`default_nettype none
module lsfe_parse (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            accept,
   input  wire logic                            data_bit,
   input  wire logic                            start_of_image,
   input  wire logic [lsfe_pkg::HDR_LEN_W-1:0]  header_length,
   input  wire logic [lsfe_pkg::MAGIC_W-1:0]    magic_length,
   output logic                                 res_valid,
   output lsfe_pkg::result_type                 res
);

   lsfe_pkg::parse_state_type state_ff;
   lsfe_pkg::parse_state_type state_in;
   lsfe_pkg::parse_state_type st;

   // Skip over phases that have nothing left to do.
   function automatic lsfe_pkg::parse_state_type settle(
      input lsfe_pkg::parse_state_type s,
      input logic [lsfe_pkg::MAGIC_W-1:0] mlen
   );
      lsfe_pkg::parse_state_type r;
      r = s;
      if (r.phase == lsfe_pkg::PH_HEADER && r.header_left == '0) begin
         r.phase      = lsfe_pkg::PH_MAGIC;
         r.items_left = {{(lsfe_pkg::VALUE_W-lsfe_pkg::MAGIC_W){1'b0}}, mlen};
      end
      if (r.phase == lsfe_pkg::PH_MAGIC && r.items_left == '0)
         r.phase = lsfe_pkg::PH_EXTLEN;
      if (r.phase == lsfe_pkg::PH_EXTBYTES && r.items_left == '0)
         r.phase = lsfe_pkg::PH_PAYLEN;
      if (r.phase == lsfe_pkg::PH_PAYBYTES && r.items_left == '0)
         r.phase = lsfe_pkg::PH_DONE;
      return r;
   endfunction

   function automatic logic [lsfe_pkg::SECTION_W-1:0] section_of(input lsfe_pkg::phase_type p);
      logic [lsfe_pkg::SECTION_W-1:0] s;
      unique case (p)
         lsfe_pkg::PH_MAGIC:    s = lsfe_pkg::SEC_MAGIC;
         lsfe_pkg::PH_EXTLEN:   s = lsfe_pkg::SEC_EXT_LEN;
         lsfe_pkg::PH_EXTBYTES: s = lsfe_pkg::SEC_EXT_BYTE;
         lsfe_pkg::PH_PAYLEN:   s = lsfe_pkg::SEC_PAY_LEN;
         default:               s = lsfe_pkg::SEC_PAY_BYTE;
      endcase
      return s;
   endfunction

   always_comb begin
      st        = state_ff;
      res_valid = 1'b0;
      res       = '0;
      if (accept) begin
         if (start_of_image) begin
            st.phase       = lsfe_pkg::PH_HEADER;
            st.header_left = header_length;
            st.bit_count   = '0;
            st.shift_word  = '0;
            st.items_left  = '0;
         end
         st = settle(st, magic_length);
         unique case (st.phase)
            lsfe_pkg::PH_HEADER: begin
               st.header_left = st.header_left - 1'b1;
            end
            lsfe_pkg::PH_MAGIC, lsfe_pkg::PH_EXTBYTES, lsfe_pkg::PH_PAYBYTES: begin
               st.shift_word = {st.shift_word[lsfe_pkg::VALUE_W-2:0], data_bit};
               if (st.bit_count != lsfe_pkg::BYTE_LAST_BIT) begin
                  st.bit_count = st.bit_count + 1'b1;
               end else begin
                  st.bit_count = '0;
                  st.items_left = st.items_left - 1'b1;
                  res_valid = 1'b1;
                  res.out_value = {{(lsfe_pkg::VALUE_W-8){1'b0}}, st.shift_word[7:0]};
                  res.section = section_of(st.phase);
                  res.last_in_section = (st.items_left == '0);
                  st.shift_word = '0;
                  if (st.items_left == '0) begin
                     priority if (st.phase == lsfe_pkg::PH_MAGIC)
                        st.phase = lsfe_pkg::PH_EXTLEN;
                     else if (st.phase == lsfe_pkg::PH_EXTBYTES)
                        st.phase = lsfe_pkg::PH_PAYLEN;
                     else
                        st.phase = lsfe_pkg::PH_DONE;
                  end
               end
            end
            lsfe_pkg::PH_EXTLEN, lsfe_pkg::PH_PAYLEN: begin
               st.shift_word = {st.shift_word[lsfe_pkg::VALUE_W-2:0], data_bit};
               if (st.bit_count != lsfe_pkg::WORD_LAST_BIT) begin
                  st.bit_count = st.bit_count + 1'b1;
               end else begin
                  st.bit_count = '0;
                  res_valid = 1'b1;
                  res.out_value = st.shift_word;
                  res.section = section_of(st.phase);
                  res.last_in_section = 1'b1;
                  // A length with the top bit set describes an empty section.
                  st.items_left = st.shift_word[lsfe_pkg::VALUE_W-1] ? '0 : st.shift_word;
                  st.phase = (st.phase == lsfe_pkg::PH_EXTLEN) ? lsfe_pkg::PH_EXTBYTES
                                                               : lsfe_pkg::PH_PAYBYTES;
                  st.shift_word = '0;
                  st = settle(st, magic_length);
               end
            end
            default: begin
            end
         endcase
      end
      state_in = st;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.phase       <= lsfe_pkg::PH_HEADER;
         state_ff.bit_count   <= '0;
         state_ff.shift_word  <= '0;
         state_ff.items_left  <= '0;
         state_ff.header_left <= lsfe_pkg::HEADER_LENGTH_RESET;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule
`default_nettype wire

>>> sv/lsfe_obuf.sv
// Two-entry result buffer: output register plus skid register.
`default_nettype none
module lsfe_obuf (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 push,
   input  wire lsfe_pkg::result_type push_data,
   output logic                      full,
   output logic                      out_valid,
   output lsfe_pkg::result_type      out_data,
   input  wire logic                 out_stall
);

   logic                 head_valid_ff, head_valid_in;
   logic                 skid_valid_ff, skid_valid_in;
   lsfe_pkg::result_type head_ff, head_in;
   lsfe_pkg::result_type skid_ff, skid_in;
   logic                 pop;

   assign pop = head_valid_ff && !out_stall;

   always_comb begin
      head_valid_in = head_valid_ff;
      skid_valid_in = skid_valid_ff;
      head_in       = head_ff;
      skid_in       = skid_ff;
      if (!head_valid_ff || pop) begin
         if (skid_valid_ff) begin
            head_valid_in = 1'b1;
            head_in       = skid_ff;
            skid_valid_in = 1'b0;
         end else begin
            head_valid_in = push;
            head_in       = push_data;
         end
      end else if (push) begin
         skid_valid_in = 1'b1;
         skid_in       = push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         head_valid_ff <= head_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      head_ff <= head_in;
      skid_ff <= skid_in;
   end

   assign full      = skid_valid_ff;
   assign out_valid = head_valid_ff;
   assign out_data  = head_ff;

endmodule
`default_nettype wire

>>> sv/lsb_stego_frame_extractor.sv
// Top level of the LSB stego frame extractor: config registers, parser, result buffer.
// Each result is registered in the result buffer before it reaches the rsp_ ports.
// Throughput: one item per cycle unless req_stall; parse state updates per accepted item.
// The two-entry result buffer lets an item enter while a finished result still waits.
// Reset (synchronous, active high) restores header_length 54, magic_length 2, the header
// skip phase with 54 bytes to skip, and empties the result buffer.
`default_nettype none
module lsb_stego_frame_extractor (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              csr_write_enable,
   input  wire logic [lsfe_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire logic [lsfe_pkg::CSR_DAT_W-1:0]    csr_write_data,
   input  wire logic                              req_valid,
   output logic                                   req_stall,
   input  wire logic [7:0]                        req_image_byte,
   input  wire logic                              req_start_of_image,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_stall,
   output logic [lsfe_pkg::VALUE_W-1:0]           rsp_out_value,
   output logic [lsfe_pkg::SECTION_W-1:0]         rsp_section,
   output logic                                   rsp_last_in_section
);

   logic [lsfe_pkg::HDR_LEN_W-1:0] header_length_ff;
   logic [lsfe_pkg::MAGIC_W-1:0]   magic_length_ff;
   logic                           req_accept;
   logic                           res_valid;
   lsfe_pkg::result_type           res;
   lsfe_pkg::result_type           rsp_data;
   logic                           buf_full;

   // Configuration registers; write only while the block is idle (not enforced here).
   always_ff @(posedge clock) begin
      if (reset) begin
         header_length_ff <= lsfe_pkg::HEADER_LENGTH_RESET;
         magic_length_ff  <= lsfe_pkg::MAGIC_LENGTH_RESET;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            lsfe_pkg::CSR_HEADER_LENGTH: header_length_ff <= csr_write_data;
            lsfe_pkg::CSR_MAGIC_LENGTH:  magic_length_ff  <= csr_write_data[lsfe_pkg::MAGIC_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // The input side stalls only when both buffer entries hold results.
   assign req_stall  = buf_full;
   assign req_accept = req_valid && !req_stall;

   // Only bit 0 of each image byte carries hidden data.
   lsfe_parse u_parse (
      .clock          (clock),
      .reset          (reset),
      .accept         (req_accept),
      .data_bit       (req_image_byte[0]),
      .start_of_image (req_start_of_image),
      .header_length  (header_length_ff),
      .magic_length   (magic_length_ff),
      .res_valid      (res_valid),
      .res            (res)
   );

   lsfe_obuf u_obuf (
      .clock     (clock),
      .reset     (reset),
      .push      (res_valid),
      .push_data (res),
      .full      (buf_full),
      .out_valid (rsp_valid),
      .out_data  (rsp_data),
      .out_stall (rsp_stall)
   );

   assign rsp_out_value       = rsp_data.out_value;
   assign rsp_section         = rsp_data.section;
   assign rsp_last_in_section = rsp_data.last_in_section;

   // A result is only ever produced by an accepted item.
   a_res_needs_accept: assert property (@(posedge clock) disable iff (reset)
      res_valid |-> req_accept)
      else $error("result produced without an accepted item");

   // The skid entry is only occupied behind a waiting output.
   a_skid_behind_head: assert property (@(posedge clock) disable iff (reset)
      buf_full |-> rsp_valid)
      else $error("skid entry holds a result while output is empty");

   // A start-of-image byte with a nonzero header is always skipped.
   a_start_in_header: assert property (@(posedge clock) disable iff (reset)
      (req_accept && req_start_of_image && header_length_ff != '0) |-> !res_valid)
      else $error("result produced by first header byte");

   // Length words always close their section.
   a_len_is_last: assert property (@(posedge clock) disable iff (reset)
      (res_valid && (res.section == lsfe_pkg::SEC_EXT_LEN ||
                     res.section == lsfe_pkg::SEC_PAY_LEN)) |-> res.last_in_section)
      else $error("length word not marked last in section");

endmodule
`default_nettype wire
